// File: hdl/pnsb_pkg.sv
// ----------------------------------------------------------------------------
// pnsb_pkg
// shared types, codes and constants of the palette scaler blit block
// ----------------------------------------------------------------------------
package pnsb_pkg;

	localparam int unsigned PALETTE_SIZE_DEF  = 256;
	localparam int unsigned SOURCE_PIXELS_DEF = 65536;
	localparam int unsigned FRAC_BITS_DEF     = 16;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	localparam int unsigned DIM_W    = 11;
	localparam int unsigned TDIM_W   = 13;
	localparam int unsigned COORD_W  = 13;
	localparam int unsigned TADDR_W  = 24;
	localparam int unsigned COLOR_W  = 24;
	localparam int unsigned SRCA_W   = 22;

	typedef enum logic [1:0] {
		CMD_PAL_WR  = 2'd0,
		CMD_SRC_WR  = 2'd1,
		CMD_BLIT    = 2'd2,
		CMD_ADVANCE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_RENDER_W  = 3'd0,
		REG_RENDER_H  = 3'd1,
		REG_TARGET_W  = 3'd2,
		REG_TARGET_H  = 3'd3,
		REG_STRIDE    = 3'd4,
		REG_RED_LOW   = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		DIV_SCALE_X = 3'd0,
		DIV_SCALE_Y = 3'd1,
		DIV_X0      = 3'd2,
		DIV_X1      = 3'd3,
		DIV_Y0      = 3'd4,
		DIV_Y1      = 3'd5
	} div_sel_t;

	typedef struct packed {
		logic [DIM_W-1:0]  render_width;
		logic [DIM_W-1:0]  render_height;
		logic [TDIM_W-1:0] target_width;
		logic [TDIM_W-1:0] target_height;
		logic [TDIM_W-1:0] target_stride;
		logic              red_low_order;
	} cfg_t;

	typedef struct packed {
		logic     pal_wr;
		logic     src_wr;
		logic     blit_start;
		logic     div_load;
		logic     div_store;
		div_sel_t div_sel;
		logic     blit_finish;
		logic     px_mul;
		logic     px_addr;
		logic     px_src;
		logic     px_pal;
		logic     px_out;
	} ctl_t;

	typedef struct packed {
		logic sizes_zero;
		logic scale_zero;
		logic div_done;
		logic blit_active;
	} sts_t;

endpackage

// File: hdl/pnsb_div.sv
// ----------------------------------------------------------------------------
// pnsb_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pnsb_div #(
	parameter int unsigned NUM_W = 28,
	parameter int unsigned DEN_W = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_nx;
	logic           fits;

	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		fits   = (rem_sh >= {1'b0, den_q});
		rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (load) begin
			rem_q  <= '0;
			quo_q  <= num;
			den_q  <= den;
			cnt_q  <= CNT_W'(NUM_W);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			rem_q  <= rem_nx;
			quo_q  <= {quo_q[NUM_W-2:0], fits};
			cnt_q  <= cnt_q - CNT_W'(1);
			run_q  <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// File: hdl/pnsb_datapath.sv
// ----------------------------------------------------------------------------
// pnsb_datapath
// palette and source stores, blit setup arithmetic and pixel address path
// ----------------------------------------------------------------------------
module pnsb_datapath #(
	parameter int unsigned PALETTE_SIZE        = pnsb_pkg::PALETTE_SIZE_DEF,
	parameter int unsigned SOURCE_STORE_PIXELS = pnsb_pkg::SOURCE_PIXELS_DEF,
	parameter int unsigned SCALE_FRACTION_BITS = pnsb_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pnsb_pkg::cfg_t                      cfg,
	input  pnsb_pkg::ctl_t                      ctl,
	output pnsb_pkg::sts_t                      sts,
	input  logic [7:0]                          palette_entry,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	input  logic [15:0]                         src_address,
	input  logic [7:0]                          src_value,
	input  logic signed [12:0]                  rect_x,
	input  logic signed [12:0]                  rect_y,
	input  logic signed [12:0]                  rect_w,
	input  logic signed [12:0]                  rect_h,
	output logic [pnsb_pkg::TADDR_W-1:0]        target_address,
	output logic [pnsb_pkg::COLOR_W-1:0]        pixel_color,
	output logic                                last_pixel,
	output logic                                valid
);

	localparam int unsigned FB   = SCALE_FRACTION_BITS;
	localparam int unsigned SW   = pnsb_pkg::DIM_W + FB;
	localparam int unsigned QW   = SW + 1;
	localparam int unsigned CW   = pnsb_pkg::COORD_W;
	localparam int unsigned PW   = CW + SW;
	localparam int unsigned NW   = PW - FB;
	localparam int unsigned PAW  = $clog2(PALETTE_SIZE);
	localparam int unsigned SAW  = $clog2(SOURCE_STORE_PIXELS);
	localparam int unsigned AW   = pnsb_pkg::SRCA_W;
	localparam int unsigned TAW  = 2 * CW + 1;

	typedef struct packed {
		logic [11:0] p;
		logic [10:0] e;
	} axis_t;

	function automatic axis_t clip_axis(input logic signed [12:0] pos,
		input logic signed [12:0] len, input logic [10:0] lim);
		logic signed [14:0] p;
		logic signed [14:0] l;
		logic signed [14:0] s;
		axis_t r;
		p = {{2{pos[12]}}, pos};
		l = {{2{len[12]}}, len};
		if (p < 0) begin
			l = l + p;
			p = '0;
		end
		s = p + l;
		if (s > $signed({4'b0000, lim})) begin
			r.e = lim;
		end else if (s < 0) begin
			r.e = '0;
		end else begin
			r.e = s[10:0];
		end
		r.p = p[11:0];
		return r;
	endfunction

	function automatic logic [10:0] clamp_src(input logic [NW-1:0] s, input logic [10:0] lim);
		logic [10:0] r;
		if (lim == '0) begin
			r = '0;
		end else if (s >= NW'(lim)) begin
			r = lim - 11'd1;
		end else begin
			r = s[10:0];
		end
		return r;
	endfunction

	// memories
	logic [23:0] pal_mem [PALETTE_SIZE];
	logic [7:0]  src_mem [SOURCE_STORE_PIXELS];

	// blit state
	logic signed [12:0] rx_q, ry_q, rw_q, rh_q;
	logic [SW-1:0]      scale_x_q, scale_y_q;
	logic [QW-1:0]      x0_q, y0_q;
	logic [CW-1:0]      col_start_q, col_end_q, row_end_q, cur_col_q, cur_row_q;
	logic               blit_active_q;

	// pixel path
	logic [PW-1:0]  prod_x_q, prod_y_q;
	logic [TAW-1:0] taddr_q;
	logic [AW-1:0]  src_addr_q;
	logic           src_ok_q;
	logic [7:0]     src_rd_q;
	logic           pal_ok_q;
	logic [23:0]    pal_rd_q;
	logic           valid_q;
	logic           last_q;
	logic [pnsb_pkg::TADDR_W-1:0] taddr_out_q;
	logic [pnsb_pkg::COLOR_W-1:0] color_out_q;

	// divider
	logic [QW-1:0] div_num;
	logic [SW-1:0] div_den;
	logic [QW-1:0] div_quo;
	logic          div_done;

	axis_t         xa, ya;
	logic [10:0]   sx, sy;
	logic [AW-1:0] src_addr_d;
	logic [AW-1:0] src_wr_ext;
	logic          src_wr_ok;
	logic          pal_wr_ok;
	logic [23:0]   pal_wr_data;
	logic [7:0]    pal_idx;
	logic [CW:0]   col_next;
	logic [CW:0]   row_next;
	logic          is_last;

	always_comb begin
		xa = clip_axis(rx_q, rw_q, cfg.render_width);
		ya = clip_axis(ry_q, rh_q, cfg.render_height);
		div_num = '0;
		div_den = scale_x_q;
		case (ctl.div_sel)
			pnsb_pkg::DIV_SCALE_X: begin
				div_num = {1'b0, cfg.render_width, {FB{1'b0}}};
				div_den = SW'(cfg.target_width);
			end
			pnsb_pkg::DIV_SCALE_Y: begin
				div_num = {1'b0, cfg.render_height, {FB{1'b0}}};
				div_den = SW'(cfg.target_height);
			end
			pnsb_pkg::DIV_X0: begin
				div_num = {xa.p, {FB{1'b0}}};
				div_den = scale_x_q;
			end
			pnsb_pkg::DIV_X1: begin
				div_num = {1'b0, xa.e, {FB{1'b0}}};
				div_den = scale_x_q;
			end
			pnsb_pkg::DIV_Y0: begin
				div_num = {ya.p, {FB{1'b0}}};
				div_den = scale_y_q;
			end
			pnsb_pkg::DIV_Y1: begin
				div_num = {1'b0, ya.e, {FB{1'b0}}};
				div_den = scale_y_q;
			end
			default: begin
				div_num = '0;
				div_den = scale_x_q;
			end
		endcase
	end

	pnsb_div #(
		.NUM_W (QW),
		.DEN_W (SW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctl.div_load),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_comb begin
		sy = clamp_src(prod_y_q[PW-1:FB], cfg.render_height);
		sx = clamp_src(prod_x_q[PW-1:FB], cfg.render_width);
		src_addr_d = AW'(sy) * AW'(cfg.render_width) + AW'(sx);
		src_wr_ext = AW'(src_address);
		src_wr_ok  = (src_wr_ext < AW'(SOURCE_STORE_PIXELS));
		pal_wr_ok  = ({1'b0, palette_entry} < 9'(PALETTE_SIZE));
		pal_wr_data = cfg.red_low_order
			? {blue[7:2], 2'b00, green[7:2], 2'b00, red[7:2], 2'b00}
			: {red[7:2], 2'b00, green[7:2], 2'b00, blue[7:2], 2'b00};
		pal_idx  = src_ok_q ? src_rd_q : 8'd0;
		col_next = {1'b0, cur_col_q} + (CW+1)'(1);
		row_next = {1'b0, cur_row_q} + (CW+1)'(1);
		is_last  = (col_next >= {1'b0, col_end_q}) && (row_next >= {1'b0, row_end_q});
	end

	always_ff @(posedge clk) begin
		if (ctl.pal_wr && pal_wr_ok) begin
			pal_mem[palette_entry[PAW-1:0]] <= pal_wr_data;
		end
		if (ctl.px_pal) begin
			pal_rd_q <= pal_mem[pal_idx[PAW-1:0]];
			pal_ok_q <= ({1'b0, pal_idx} < 9'(PALETTE_SIZE));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.src_wr && src_wr_ok) begin
			src_mem[src_wr_ext[SAW-1:0]] <= src_value;
		end
		if (ctl.px_src) begin
			src_rd_q <= src_mem[src_addr_q[SAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.blit_start) begin
			rx_q <= rect_x;
			ry_q <= rect_y;
			rw_q <= rect_w;
			rh_q <= rect_h;
		end
		if (ctl.px_mul) begin
			prod_y_q <= PW'(cur_row_q) * PW'(scale_y_q);
			prod_x_q <= PW'(cur_col_q) * PW'(scale_x_q);
			taddr_q  <= TAW'(cur_row_q) * TAW'(cfg.target_stride) + TAW'(cur_col_q);
		end
		if (ctl.px_addr) begin
			src_addr_q <= src_addr_d;
			src_ok_q   <= (src_addr_d < AW'(SOURCE_STORE_PIXELS));
		end
		if (ctl.px_out) begin
			taddr_out_q <= taddr_q[pnsb_pkg::TADDR_W-1:0];
			color_out_q <= pal_ok_q ? pal_rd_q : '0;
			last_q      <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q     <= '0;
			scale_y_q     <= '0;
			x0_q          <= '0;
			y0_q          <= '0;
			col_start_q   <= '0;
			col_end_q     <= '0;
			row_end_q     <= '0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			blit_active_q <= 1'b0;
			valid_q       <= 1'b0;
		end else begin
			valid_q <= ctl.px_out;
			if (ctl.blit_start) begin
				blit_active_q <= 1'b0;
			end
			if (ctl.div_store) begin
				case (ctl.div_sel)
					pnsb_pkg::DIV_SCALE_X: scale_x_q <= div_quo[SW-1:0];
					pnsb_pkg::DIV_SCALE_Y: scale_y_q <= div_quo[SW-1:0];
					pnsb_pkg::DIV_X0:      x0_q <= div_quo;
					pnsb_pkg::DIV_X1: begin
						col_end_q <= (div_quo > QW'(cfg.target_width))
							? cfg.target_width : div_quo[CW-1:0];
					end
					pnsb_pkg::DIV_Y0:      y0_q <= div_quo;
					pnsb_pkg::DIV_Y1: begin
						row_end_q <= (div_quo > QW'(cfg.target_height))
							? cfg.target_height : div_quo[CW-1:0];
					end
					default: ;
				endcase
			end
			if (ctl.blit_finish) begin
				if ((QW'(col_end_q) > x0_q) && (QW'(row_end_q) > y0_q)) begin
					col_start_q   <= x0_q[CW-1:0];
					cur_col_q     <= x0_q[CW-1:0];
					cur_row_q     <= y0_q[CW-1:0];
					blit_active_q <= 1'b1;
				end
			end
			if (ctl.px_out) begin
				if (col_next >= {1'b0, col_end_q}) begin
					cur_col_q <= col_start_q;
					cur_row_q <= row_next[CW-1:0];
				end else begin
					cur_col_q <= col_next[CW-1:0];
				end
				if (is_last) begin
					blit_active_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		sts.sizes_zero  = (cfg.render_width == '0) || (cfg.render_height == '0) ||
			(cfg.target_width == '0) || (cfg.target_height == '0);
		sts.scale_zero  = (scale_x_q == '0) || (scale_y_q == '0);
		sts.div_done    = div_done;
		sts.blit_active = blit_active_q;
	end

	assign target_address = taddr_out_q;
	assign pixel_color    = color_out_q;
	assign last_pixel     = last_q;
	assign valid          = valid_q;

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(ctl.px_out))
		else $error("result strobe without a pixel output step");

	a_active_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		blit_active_q |-> (cur_col_q < col_end_q) && (cur_row_q < row_end_q) &&
			(col_start_q < col_end_q))
		else $error("pixel walk outside the target rectangle");

	a_last_ends_blit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> !blit_active_q)
		else $error("blit still active after its last pixel");

endmodule

// File: hdl/pnsb_ctrl.sv
// ----------------------------------------------------------------------------
// pnsb_ctrl
// command sequencer: store writes, blit setup divisions, pixel steps
// ----------------------------------------------------------------------------
module pnsb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     cmd,
	output logic           busy,
	input  pnsb_pkg::sts_t sts,
	output pnsb_pkg::ctl_t ctl
);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_DIV_LOAD = 9'b000000010,
		ST_DIV_RUN  = 9'b000000100,
		ST_FINISH   = 9'b000001000,
		ST_PX_MUL   = 9'b000010000,
		ST_PX_ADDR  = 9'b000100000,
		ST_PX_SRC   = 9'b001000000,
		ST_PX_PAL   = 9'b010000000,
		ST_PX_OUT   = 9'b100000000
	} state_t;

	state_t              state_q, state_d;
	pnsb_pkg::div_sel_t  sel_q, sel_d;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		ctl     = '0;
		ctl.div_sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						pnsb_pkg::CMD_PAL_WR: ctl.pal_wr = 1'b1;
						pnsb_pkg::CMD_SRC_WR: ctl.src_wr = 1'b1;
						pnsb_pkg::CMD_BLIT: begin
							ctl.blit_start = 1'b1;
							sel_d = pnsb_pkg::DIV_SCALE_X;
							if (!sts.sizes_zero) begin
								state_d = ST_DIV_LOAD;
							end
						end
						pnsb_pkg::CMD_ADVANCE: begin
							if (sts.blit_active) begin
								state_d = ST_PX_MUL;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DIV_LOAD: begin
				if ((sel_q == pnsb_pkg::DIV_X0) && sts.scale_zero) begin
					state_d = ST_IDLE;
				end else begin
					ctl.div_load = 1'b1;
					state_d = ST_DIV_RUN;
				end
			end
			ST_DIV_RUN: begin
				if (sts.div_done) begin
					ctl.div_store = 1'b1;
					state_d = ST_DIV_LOAD;
					case (sel_q)
						pnsb_pkg::DIV_SCALE_X: sel_d = pnsb_pkg::DIV_SCALE_Y;
						pnsb_pkg::DIV_SCALE_Y: sel_d = pnsb_pkg::DIV_X0;
						pnsb_pkg::DIV_X0:      sel_d = pnsb_pkg::DIV_X1;
						pnsb_pkg::DIV_X1:      sel_d = pnsb_pkg::DIV_Y0;
						pnsb_pkg::DIV_Y0:      sel_d = pnsb_pkg::DIV_Y1;
						default:               state_d = ST_FINISH;
					endcase
				end
			end
			ST_FINISH: begin
				ctl.blit_finish = 1'b1;
				state_d = ST_IDLE;
			end
			ST_PX_MUL: begin
				ctl.px_mul = 1'b1;
				state_d = ST_PX_ADDR;
			end
			ST_PX_ADDR: begin
				ctl.px_addr = 1'b1;
				state_d = ST_PX_SRC;
			end
			ST_PX_SRC: begin
				ctl.px_src = 1'b1;
				state_d = ST_PX_PAL;
			end
			ST_PX_PAL: begin
				ctl.px_pal = 1'b1;
				state_d = ST_PX_OUT;
			end
			ST_PX_OUT: begin
				ctl.px_out = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= pnsb_pkg::DIV_SCALE_X;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_px_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PX_MUL) |-> sts.blit_active)
		else $error("pixel step started with no active blit");

	a_div_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIV_RUN))
		else $error("divider finished outside the division wait");

	a_busy_during_setup: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_load |=> busy && !ctl.blit_start)
		else $error("new command taken during blit setup");

endmodule

// File: hdl/palette_nearest_scaler_blit.sv
// ----------------------------------------------------------------------------
// palette_nearest_scaler_blit
// nearest neighbor scaler with 256 color palette lookup and 8-bit source frame
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// command   in         start & !busy                cmd, palette_entry, red, green, blue,
//                                                   src_address, src_value, rect_x..rect_h
// result    out        valid, one cycle, no stall   target_address, pixel_color, last_pixel
// config    in         apb write, pready always 1   render/target sizes, stride, red order
//
// palette write, source write and idle advance: busy stays low, one item per cycle
// advance: busy through the multiply, address, source read, palette read and output steps,
//   valid in the same cycle that busy drops; the source and palette reads are registered
// blit: busy through up to six divisions on one shared divider that retires one quotient
//   bit per cycle; setup stops after the two scale divisions when either scale is zero
// reset clears the blit state but the latched rectangle and sets config to defaults; store contents stay unknown
// results cannot be held off: valid marks each result for exactly one cycle
// ----------------------------------------------------------------------------
module palette_nearest_scaler_blit #(
	parameter int unsigned PALETTE_SIZE        = pnsb_pkg::PALETTE_SIZE_DEF,
	parameter int unsigned SOURCE_STORE_PIXELS = pnsb_pkg::SOURCE_PIXELS_DEF,
	parameter int unsigned SCALE_FRACTION_BITS = pnsb_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          cmd,
	input  logic [7:0]                          palette_entry,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	input  logic [15:0]                         src_address,
	input  logic [7:0]                          src_value,
	input  logic signed [12:0]                  rect_x,
	input  logic signed [12:0]                  rect_y,
	input  logic signed [12:0]                  rect_w,
	input  logic signed [12:0]                  rect_h,
	output logic                                valid,
	output logic [pnsb_pkg::TADDR_W-1:0]        target_address,
	output logic [pnsb_pkg::COLOR_W-1:0]        pixel_color,
	output logic                                last_pixel,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pnsb_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pnsb_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pnsb_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	pnsb_pkg::cfg_t cfg_q;
	pnsb_pkg::ctl_t ctl;
	pnsb_pkg::sts_t sts;
	logic           cfg_wr;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[pnsb_pkg::APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.render_width  <= 11'd320;
			cfg_q.render_height <= 11'd200;
			cfg_q.target_width  <= 13'd640;
			cfg_q.target_height <= 13'd400;
			cfg_q.target_stride <= 13'd640;
			cfg_q.red_low_order <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				pnsb_pkg::REG_RENDER_W: cfg_q.render_width  <= pwdata[10:0];
				pnsb_pkg::REG_RENDER_H: cfg_q.render_height <= pwdata[10:0];
				pnsb_pkg::REG_TARGET_W: cfg_q.target_width  <= pwdata[12:0];
				pnsb_pkg::REG_TARGET_H: cfg_q.target_height <= pwdata[12:0];
				pnsb_pkg::REG_STRIDE:   cfg_q.target_stride <= pwdata[12:0];
				pnsb_pkg::REG_RED_LOW:  cfg_q.red_low_order <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pnsb_pkg::REG_RENDER_W: prdata = 32'(cfg_q.render_width);
			pnsb_pkg::REG_RENDER_H: prdata = 32'(cfg_q.render_height);
			pnsb_pkg::REG_TARGET_W: prdata = 32'(cfg_q.target_width);
			pnsb_pkg::REG_TARGET_H: prdata = 32'(cfg_q.target_height);
			pnsb_pkg::REG_STRIDE:   prdata = 32'(cfg_q.target_stride);
			pnsb_pkg::REG_RED_LOW:  prdata = 32'(cfg_q.red_low_order);
			default:                prdata = '0;
		endcase
	end

	pnsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	pnsb_datapath #(
		.PALETTE_SIZE        (PALETTE_SIZE),
		.SOURCE_STORE_PIXELS (SOURCE_STORE_PIXELS),
		.SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.ctl            (ctl),
		.sts            (sts),
		.palette_entry  (palette_entry),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.src_address    (src_address),
		.src_value      (src_value),
		.rect_x         (rect_x),
		.rect_y         (rect_y),
		.rect_w         (rect_w),
		.rect_h         (rect_h),
		.target_address (target_address),
		.pixel_color    (pixel_color),
		.last_pixel     (last_pixel),
		.valid          (valid)
	);

endmodule
